// ===== sv/grcu_pkg.sv =====
// ----------------------------------------------------------------------------
// grcu_pkg
// Shared constants, register indexes and knot math for the gated recurrent
// cell update block.
// ----------------------------------------------------------------------------
package grcu_pkg;

    // Default number of PWL segments per activation
    localparam int PWL_SEGMENTS_DEF = 32;

    // Register stages inside one PWL activation unit
    localparam int PWL_LAT = 6;

    // Fixed-point one
    localparam int ONE_Q12 = 4096;
    localparam longint unsigned ONE_Q24 = 64'd16777216;

    // e^-(2^b/4096) in Q24, one entry per input bit
    localparam longint unsigned EXP_NEG_Q24 [16] = '{
        64'd16773120, 64'd16769026, 64'd16760840, 64'd16744480,
        64'd16711808, 64'd16646655, 64'd16517109, 64'd16261035,
        64'd15760736, 64'd14805841, 64'd13066109, 64'd10175896,
        64'd6171993,  64'd2270549,  64'd307285,   64'd5628
    };

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TRAINING  = 2'd0,
        CFG_ZO_ENABLE = 2'd1,
        CFG_ZO_PROB   = 2'd2
    } t_cfg_idx;

    // Unsigned quotient by shift and subtract, one bit per step.
    // Evaluated at elaboration only.
    function automatic longint unsigned udiv(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned q;
        longint unsigned rem;
        int              i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Activation value at knot x (Q3.12): sigmoid in Q0.12 or tanh in Q3.12.
    // Evaluated at elaboration only, to fill the knot tables.
    function automatic int knot_value(input int x, input bit is_tanh);
        longint unsigned t;
        longint unsigned p;
        longint unsigned e2;
        longint unsigned d;
        longint unsigned y;
        int              r;
        int              b;
        t = longint'((x < 0) ? -x : x);
        p = ONE_Q24;
        // Product of one exp factor per set bit of the magnitude
        for (b = 0; b < 16; b++) begin
            if (t[b]) begin
                p = (p * EXP_NEG_Q24[b] + (ONE_Q24 >> 1)) >> 24;
            end
        end
        if (is_tanh) begin
            e2 = (p * p + (ONE_Q24 >> 1)) >> 24;
            d  = ONE_Q24 + e2;
            y  = udiv(64'(ONE_Q12) * (ONE_Q24 - e2) + (d >> 1), d);
            r  = int'(y);
            return (x < 0) ? -r : r;
        end
        d = ONE_Q24 + p;
        y = udiv(64'(ONE_Q12) * ONE_Q24 + (d >> 1), d);
        r = int'(y);
        return (x < 0) ? (ONE_Q12 - r) : r;
    endfunction

endpackage

// ===== sv/gated_recurrent_cell_update_top.sv =====
// ----------------------------------------------------------------------------
// gated_recurrent_cell_update_top
// Pointwise update of a recurrent cell with an update gate and no reset gate:
// saturated term sums, PWL sigmoid and tanh, hidden blend and zoneout.
//
//   Channel   Handshake              Payload
//   -------   ---------------------  ---------------------------------------
//   request   start && !busy         i_update_*, i_cand_*, prev, keep mask
//   result    o_strobe (one cycle)   new hidden, gate, candidate, act valid
//   config    i_cfg_we               i_cfg_index, i_cfg_data
//
// One request per cycle, as busy stays low. Each request passes the sum
// stage, the six-stage PWL divide path, then the product, blend, zoneout
// product and output stages. Reset clears the valid line and the config
// registers; payload is not reset. The result is never held.
// ----------------------------------------------------------------------------
module gated_recurrent_cell_update_top #(
    parameter int PWL_SEGMENTS = grcu_pkg::PWL_SEGMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    input  logic signed [15:0] i_update_input_proj,
    input  logic signed [15:0] i_update_recur_proj,
    input  logic signed [15:0] i_update_in_bias,
    input  logic signed [15:0] i_update_hid_bias,
    input  logic signed [15:0] i_cand_input_proj,
    input  logic signed [15:0] i_cand_recur_proj,
    input  logic signed [15:0] i_cand_in_bias,
    input  logic signed [15:0] i_cand_hid_bias,
    input  logic signed [15:0] i_prev_hidden,
    input  logic               i_keep_mask,
    output logic               o_strobe,
    output logic signed [15:0] o_new_hidden,
    output logic        [12:0] o_update_gate,
    output logic signed [13:0] o_candidate,
    output logic               o_activations_valid
);
    import grcu_pkg::*;

    localparam int LAT = PWL_LAT + 5;

    // Saturated sum of four Q3.12 terms
    function automatic logic signed [15:0] sum4_sat(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic signed [15:0] c,
        input logic signed [15:0] d
    );
        logic signed [17:0] s;
        s = 18'(a) + 18'(b) + 18'(c) + 18'(d);
        priority if (s > 18'sd32767) begin
            return 16'sh7FFF;
        end else if (s < -18'sd32768) begin
            return 16'sh8000;
        end else begin
            return s[15:0];
        end
    endfunction

    // Round Q24 to Q12 (add half, floor) and saturate to 16 bits
    function automatic logic signed [15:0] rnd_sat(input logic signed [30:0] v);
        logic signed [30:0] t;
        t = (v + 31'sd2048) >>> 12;
        priority if (t > 31'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -31'sd32768) begin
            return 16'sh8000;
        end else begin
            return t[15:0];
        end
    endfunction

    // Every request is taken
    assign busy = 1'b0;

    logic w_accept;
    assign w_accept = start && !busy;

    // Configuration registers
    logic        r_training;
    logic        r_zo_en;
    logic [12:0] r_zo_prob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_training <= 1'b0;
            r_zo_en    <= 1'b0;
            r_zo_prob  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TRAINING:  r_training <= i_cfg_data[0];
                CFG_ZO_ENABLE: r_zo_en    <= i_cfg_data[0];
                CFG_ZO_PROB:   r_zo_prob  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic        w_zo_active;
    logic [12:0] w_prob;
    assign w_zo_active = r_zo_en && (r_zo_prob != '0);
    assign w_prob      = (r_zo_prob > 13'(ONE_Q12)) ? 13'(ONE_Q12) : r_zo_prob;

    // Valid line, one bit per stage
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // Stage 1: term sums
    logic signed [15:0] r_s1_zsum;
    logic signed [15:0] r_s1_asum;
    logic signed [15:0] r_s1_h;
    logic               r_s1_keep;

    always_ff @(posedge i_clk) begin
        r_s1_zsum <= sum4_sat(i_update_input_proj, i_update_recur_proj,
                              i_update_in_bias, i_update_hid_bias);
        r_s1_asum <= sum4_sat(i_cand_input_proj, i_cand_recur_proj,
                              i_cand_in_bias, i_cand_hid_bias);
        r_s1_h    <= i_prev_hidden;
        r_s1_keep <= i_keep_mask;
    end

    // Activations
    logic signed [13:0] w_z;
    logic signed [13:0] w_a;

    grcu_pwl #(
        .PWL_SEGMENTS (PWL_SEGMENTS),
        .IS_TANH      (1'b0)
    ) u_sigmoid (
        .i_clk (i_clk),
        .i_x   (r_s1_zsum),
        .o_y   (w_z)
    );

    grcu_pwl #(
        .PWL_SEGMENTS (PWL_SEGMENTS),
        .IS_TANH      (1'b1)
    ) u_tanh (
        .i_clk (i_clk),
        .i_x   (r_s1_asum),
        .o_y   (w_a)
    );

    // Carry the old hidden value and mask alongside the activations
    logic signed [15:0] r_hd_h    [PWL_LAT];
    logic               r_hd_keep [PWL_LAT];

    always_ff @(posedge i_clk) begin
        r_hd_h[0]    <= r_s1_h;
        r_hd_keep[0] <= r_s1_keep;
        for (int i = 1; i < PWL_LAT; i++) begin
            r_hd_h[i]    <= r_hd_h[i-1];
            r_hd_keep[i] <= r_hd_keep[i-1];
        end
    end

    // Stage 8: gate products z*h and (1-z)*a
    logic signed [29:0] r_s8_pz;
    logic signed [27:0] r_s8_pa;
    logic signed [13:0] r_s8_z;
    logic signed [13:0] r_s8_a;
    logic signed [15:0] r_s8_h;
    logic               r_s8_keep;

    always_ff @(posedge i_clk) begin
        r_s8_pz   <= 30'(w_z) * 30'(r_hd_h[PWL_LAT-1]);
        r_s8_pa   <= 28'(14'(ONE_Q12) - w_z) * 28'(w_a);
        r_s8_z    <= w_z;
        r_s8_a    <= w_a;
        r_s8_h    <= r_hd_h[PWL_LAT-1];
        r_s8_keep <= r_hd_keep[PWL_LAT-1];
    end

    // Stage 9: blend, round, saturate
    logic signed [15:0] r_s9_hn;
    logic signed [13:0] r_s9_z;
    logic signed [13:0] r_s9_a;
    logic signed [15:0] r_s9_h;
    logic               r_s9_keep;

    always_ff @(posedge i_clk) begin
        r_s9_hn   <= rnd_sat(31'(r_s8_pz) + 31'(r_s8_pa));
        r_s9_z    <= r_s8_z;
        r_s9_a    <= r_s8_a;
        r_s9_h    <= r_s8_h;
        r_s9_keep <= r_s8_keep;
    end

    // Stage 10: inference zoneout products p*h and (1-p)*hn
    logic signed [29:0] r_s10_ph;
    logic signed [29:0] r_s10_pn;
    logic signed [15:0] r_s10_hn;
    logic signed [13:0] r_s10_z;
    logic signed [13:0] r_s10_a;
    logic signed [15:0] r_s10_h;
    logic               r_s10_keep;

    always_ff @(posedge i_clk) begin
        r_s10_ph   <= 30'(signed'({1'b0, w_prob})) * 30'(r_s9_h);
        r_s10_pn   <= 30'(signed'({1'b0, 13'(ONE_Q12) - w_prob})) * 30'(r_s9_hn);
        r_s10_hn   <= r_s9_hn;
        r_s10_z    <= r_s9_z;
        r_s10_a    <= r_s9_a;
        r_s10_h    <= r_s9_h;
        r_s10_keep <= r_s9_keep;
    end

    // Stage 11: pick the zoneout result and gate the activation outputs
    logic signed [15:0] n_hidden;

    always_comb begin
        priority if (!w_zo_active) begin
            n_hidden = r_s10_hn;
        end else if (r_training) begin
            n_hidden = r_s10_keep ? r_s10_hn : r_s10_h;
        end else begin
            n_hidden = rnd_sat(31'(r_s10_ph) + 31'(r_s10_pn));
        end
    end

    logic signed [15:0] r_out_hidden;
    logic        [12:0] r_out_gate;
    logic signed [13:0] r_out_cand;
    logic               r_out_act;

    always_ff @(posedge i_clk) begin
        r_out_hidden <= n_hidden;
        r_out_gate   <= r_training ? r_s10_z[12:0] : '0;
        r_out_cand   <= r_training ? r_s10_a : '0;
        r_out_act    <= r_training;
    end

    assign o_strobe            = r_vld[LAT-1];
    assign o_new_hidden        = r_out_hidden;
    assign o_update_gate       = r_out_gate;
    assign o_candidate         = r_out_cand;
    assign o_activations_valid = r_out_act;

    // Activation outputs follow the mode
    a_act_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_activations_valid == r_training))
        else $error("activations_valid does not follow training mode");

    a_infer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !r_training) |-> (o_update_gate == '0 && o_candidate == '0))
        else $error("activation outputs not cleared in inference");

    // PWL results stay inside their activation range
    a_act_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_update_gate <= 13'd4096 &&
                      o_candidate <= 14'sd4096 && o_candidate >= -14'sd4096))
        else $error("activation out of range");

    // Training zoneout with a clear mask keeps the old hidden value
    a_keep_old: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-2] && w_zo_active && r_training && !r_s10_keep)
            |=> (o_new_hidden == $past(r_s10_h)))
        else $error("zoneout did not keep the old hidden value");

endmodule

// ===== sv/grcu_pwl.sv =====
// ----------------------------------------------------------------------------
// grcu_pwl
// Pipelined piecewise-linear activation (sigmoid or tanh) over evenly spaced
// knots on [-8, 8]. Interpolation divides by the segment width through a
// per-segment reciprocal with a single remainder correction. Fixed latency.
// ----------------------------------------------------------------------------
module grcu_pwl #(
    parameter int PWL_SEGMENTS = grcu_pkg::PWL_SEGMENTS_DEF,
    parameter bit IS_TANH      = 1'b0
) (
    input  logic               i_clk,
    input  logic signed [15:0] i_x,
    output logic signed [13:0] o_y
);
    import grcu_pkg::*;

    localparam int SW = $clog2(PWL_SEGMENTS);   // segment index bits
    localparam int PW = 16 + SW;                // scaled offset bits
    localparam int RK = 28;                     // reciprocal fraction bits

    // Knot tables
    logic        [15:0] c_ux0 [PWL_SEGMENTS];
    logic        [13:0] c_w   [PWL_SEGMENTS];
    logic        [20:0] c_rcp [PWL_SEGMENTS];
    logic signed [13:0] c_y0  [PWL_SEGMENTS];
    logic signed [14:0] c_dy  [PWL_SEGMENTS];

    for (genvar k = 0; k < PWL_SEGMENTS; k++) begin : g_knot
        localparam int UX0 = (k * 65536) / PWL_SEGMENTS;
        localparam int UX1 = ((k + 1) * 65536) / PWL_SEGMENTS;
        localparam int W   = UX1 - UX0;
        localparam int RCP = (1 << RK) / W;
        localparam int Y0  = knot_value(UX0 - 32768, IS_TANH);
        localparam int Y1  = knot_value(UX1 - 32768, IS_TANH);
        assign c_ux0[k] = 16'(UX0);
        assign c_w[k]   = 14'(W);
        assign c_rcp[k] = 21'(RCP);
        assign c_y0[k]  = 14'(Y0);
        assign c_dy[k]  = 15'(Y1 - Y0);
    end

    // Stage 1: segment select and table read
    logic [15:0]   w_u;
    logic [PW-1:0] w_scaled;
    logic [SW-1:0] w_seg;
    logic [15:0]   w_dx;

    assign w_u      = {~i_x[15], i_x[14:0]};
    assign w_scaled = PW'(w_u) * PW'(PWL_SEGMENTS);
    assign w_seg    = w_scaled[PW-1:16];
    assign w_dx     = w_u - c_ux0[w_seg];

    logic        [13:0] r_p1_dx;
    logic signed [14:0] r_p1_dy;
    logic        [13:0] r_p1_w;
    logic        [20:0] r_p1_rcp;
    logic signed [13:0] r_p1_y0;

    always_ff @(posedge i_clk) begin
        r_p1_dx  <= w_dx[13:0];
        r_p1_dy  <= c_dy[w_seg];
        r_p1_w   <= c_w[w_seg];
        r_p1_rcp <= c_rcp[w_seg];
        r_p1_y0  <= c_y0[w_seg];
    end

    // Stage 2: slope times offset
    logic signed [29:0] r_p2_prod;
    logic        [13:0] r_p2_w;
    logic        [20:0] r_p2_rcp;
    logic signed [13:0] r_p2_y0;

    always_ff @(posedge i_clk) begin
        r_p2_prod <= 30'(r_p1_dy) * 30'(signed'({1'b0, r_p1_dx}));
        r_p2_w    <= r_p1_w;
        r_p2_rcp  <= r_p1_rcp;
        r_p2_y0   <= r_p1_y0;
    end

    // Stage 3: magnitude plus half the width, for rounding away from zero
    logic signed [29:0] w_mag;
    assign w_mag = r_p2_prod[29] ? -r_p2_prod : r_p2_prod;

    logic        [27:0] r_p3_n;
    logic               r_p3_neg;
    logic        [13:0] r_p3_w;
    logic        [20:0] r_p3_rcp;
    logic signed [13:0] r_p3_y0;

    always_ff @(posedge i_clk) begin
        r_p3_n   <= w_mag[27:0] + 28'(r_p2_w >> 1);
        r_p3_neg <= r_p2_prod[29];
        r_p3_w   <= r_p2_w;
        r_p3_rcp <= r_p2_rcp;
        r_p3_y0  <= r_p2_y0;
    end

    // Stage 4: quotient estimate from the reciprocal, low by at most one
    logic [48:0] w_qprod;
    assign w_qprod = 49'(r_p3_n) * 49'(r_p3_rcp);

    logic        [14:0] r_p4_qe;
    logic        [27:0] r_p4_n;
    logic               r_p4_neg;
    logic        [13:0] r_p4_w;
    logic signed [13:0] r_p4_y0;

    always_ff @(posedge i_clk) begin
        r_p4_qe  <= w_qprod[RK+14:RK];
        r_p4_n   <= r_p3_n;
        r_p4_neg <= r_p3_neg;
        r_p4_w   <= r_p3_w;
        r_p4_y0  <= r_p3_y0;
    end

    // Stage 5: estimate times width
    logic        [28:0] r_p5_qw;
    logic        [14:0] r_p5_qe;
    logic        [27:0] r_p5_n;
    logic               r_p5_neg;
    logic        [13:0] r_p5_w;
    logic signed [13:0] r_p5_y0;

    always_ff @(posedge i_clk) begin
        r_p5_qw  <= 29'(r_p4_qe) * 29'(r_p4_w);
        r_p5_qe  <= r_p4_qe;
        r_p5_n   <= r_p4_n;
        r_p5_neg <= r_p4_neg;
        r_p5_w   <= r_p4_w;
        r_p5_y0  <= r_p4_y0;
    end

    // Stage 6: correct the quotient, apply sign, add base knot, clamp
    logic        [28:0] w_rem;
    logic        [14:0] w_q;
    logic signed [15:0] w_sy;
    logic signed [15:0] w_lo;
    logic signed [15:0] w_hi;

    always_comb begin
        w_rem = 29'(r_p5_n) - r_p5_qw;
        w_q   = r_p5_qe + 15'((w_rem >= 29'(r_p5_w)) ? 1 : 0);
        w_sy  = r_p5_neg ? (16'(r_p5_y0) - signed'({1'b0, w_q}))
                         : (16'(r_p5_y0) + signed'({1'b0, w_q}));
        w_lo  = IS_TANH ? -16'(ONE_Q12) : 16'sd0;
        w_hi  = 16'(ONE_Q12);
    end

    logic signed [13:0] r_y;

    always_ff @(posedge i_clk) begin
        priority if (w_sy < w_lo) begin
            r_y <= 14'(w_lo);
        end else if (w_sy > w_hi) begin
            r_y <= 14'(w_hi);
        end else begin
            r_y <= w_sy[13:0];
        end
    end

    assign o_y = r_y;

endmodule

// ===== test/tb_gated_recurrent_cell_update_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gated_recurrent_cell_update_top
// Self-checking bench for the recurrent cell update block. A directed table
// runs first. It covers the field extremes, sum saturation, training and
// inference outputs, and every zoneout case. Random phases follow across
// several register settings. Every accepted request is predicted at the
// clock edge that takes it, and each strobed result is checked field by
// field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_gated_recurrent_cell_update_top;
    import grcu_pkg::*;

    localparam int SEGS        = PWL_SEGMENTS_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 212;

    typedef struct {
        logic [3:0][15:0] upd;
        logic [3:0][15:0] cand;
        logic [15:0]      prev;
        logic             keep;
    } t_cell_req;

    typedef struct {
        logic signed [15:0] new_hidden;
        logic        [12:0] update_gate;
        logic signed [13:0] candidate;
        logic               act_valid;
    } t_hidden_result;

    typedef struct {
        bit             training;
        bit             zo_en;
        logic [12:0]    zo_prob;
        t_cell_req      req;
        bit             typed;
        t_hidden_result want;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [12:0]        i_cfg_data;
    logic               o_strobe;
    logic signed [15:0] o_new_hidden;
    logic        [12:0] o_update_gate;
    logic signed [13:0] o_candidate;
    logic               o_activations_valid;

    t_cell_req      req_cur;
    bit             req_typed;
    t_hidden_result req_want;

    // Register copies seen by the predictor
    bit          cfg_training;
    bit          cfg_zo_en;
    logic [12:0] cfg_zo_prob;

    int sig_knot  [SEGS+1];
    int tanh_knot [SEGS+1];

    t_hidden_result pending_hidden[$];
    t_dir_row       dir_rows[$];
    int             n_accepted;
    int             n_mismatch;
    int             idle_cycles;

    gated_recurrent_cell_update_top #(
        .PWL_SEGMENTS(SEGS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_update_input_proj (req_cur.upd[0]),
        .i_update_recur_proj (req_cur.upd[1]),
        .i_update_in_bias    (req_cur.upd[2]),
        .i_update_hid_bias   (req_cur.upd[3]),
        .i_cand_input_proj   (req_cur.cand[0]),
        .i_cand_recur_proj   (req_cur.cand[1]),
        .i_cand_in_bias      (req_cur.cand[2]),
        .i_cand_hid_bias     (req_cur.cand[3]),
        .i_prev_hidden       (req_cur.prev),
        .i_keep_mask         (req_cur.keep),
        .o_strobe            (o_strobe),
        .o_new_hidden        (o_new_hidden),
        .o_update_gate       (o_update_gate),
        .o_candidate         (o_candidate),
        .o_activations_valid (o_activations_valid)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // e^-(2^b/4096) in Q24
    function automatic longint unsigned exp_step_q24(int b);
        case (b)
            0:  return 64'd16773120;
            1:  return 64'd16769026;
            2:  return 64'd16760840;
            3:  return 64'd16744480;
            4:  return 64'd16711808;
            5:  return 64'd16646655;
            6:  return 64'd16517109;
            7:  return 64'd16261035;
            8:  return 64'd15760736;
            9:  return 64'd14805841;
            10: return 64'd13066109;
            11: return 64'd10175896;
            12: return 64'd6171993;
            13: return 64'd2270549;
            14: return 64'd307285;
            default: return 64'd5628;
        endcase
    endfunction

    // Activation level at one knot, built from the bitwise exp product
    function automatic int knot_level(int x, bit is_tanh);
        int unsigned       mag;
        longint unsigned   e;
        longint unsigned   e2;
        longint unsigned   d;
        longint unsigned   y;
        int                r;
        mag = (x < 0) ? -x : x;
        e   = ONE_Q24;
        for (int b = 0; b < 16; b++) begin
            if (mag[b]) begin
                e = (e * exp_step_q24(b) + (ONE_Q24 >> 1)) >> 24;
            end
        end
        if (is_tanh) begin
            e2 = (e * e + (ONE_Q24 >> 1)) >> 24;
            d  = ONE_Q24 + e2;
            y  = (64'(ONE_Q12) * (ONE_Q24 - e2) + (d >> 1)) / d;
            r  = int'(y);
            return (x < 0) ? -r : r;
        end
        d = ONE_Q24 + e;
        y = (64'(ONE_Q12) * ONE_Q24 + (d >> 1)) / d;
        r = int'(y);
        return (x < 0) ? ONE_Q12 - r : r;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Add half an LSB, then floor-divide by 2^12
    function automatic int round_q12(int v);
        return (v + 2048) >>> 12;
    endfunction

    function automatic int sum_terms(logic [3:0][15:0] t);
        int s;
        s = 0;
        for (int i = 0; i < 4; i++) begin
            s += int'($signed(t[i]));
        end
        return clamp(s, -32768, 32767);
    endfunction

    // Interpolate between the two knots around x
    function automatic int pwl_act(int x, bit is_tanh);
        int seg;
        int x0;
        int x1;
        int y0;
        int y1;
        int num;
        int q;
        int y;
        seg = ((x + 32768) * SEGS) / 65536;
        x0  = -32768 + (seg * 65536) / SEGS;
        x1  = -32768 + ((seg + 1) * 65536) / SEGS;
        y0  = is_tanh ? tanh_knot[seg] : sig_knot[seg];
        y1  = is_tanh ? tanh_knot[seg+1] : sig_knot[seg+1];
        y   = y0;
        if (x1 > x0) begin
            num = (y1 - y0) * (x - x0);
            q   = (((num < 0) ? -num : num) + (x1 - x0) / 2) / (x1 - x0);
            y   = y0 + ((num < 0) ? -q : q);
        end
        return clamp(y, is_tanh ? -ONE_Q12 : 0, ONE_Q12);
    endfunction

    function automatic t_hidden_result predict_update(t_cell_req r);
        t_hidden_result res;
        int z;
        int a;
        int h;
        int hn;
        int p;
        z  = pwl_act(sum_terms(r.upd), 1'b0);
        a  = pwl_act(sum_terms(r.cand), 1'b1);
        h  = int'($signed(r.prev));
        hn = clamp(round_q12(z * h + (ONE_Q12 - z) * a), -32768, 32767);
        // Zoneout: mask in training, probability blend in inference
        if (cfg_zo_en && cfg_zo_prob != 0) begin
            if (cfg_training) begin
                if (!r.keep) hn = h;
            end else begin
                p  = (cfg_zo_prob > ONE_Q12) ? ONE_Q12 : int'(cfg_zo_prob);
                hn = clamp(round_q12(p * h + (ONE_Q12 - p) * hn), -32768, 32767);
            end
        end
        res.new_hidden  = 16'(hn);
        res.update_gate = cfg_training ? 13'(z) : 13'd0;
        res.candidate   = cfg_training ? 14'(a) : 14'd0;
        res.act_valid   = cfg_training;
        return res;
    endfunction

    // Fill the knot tables
    initial begin
        for (int k = 0; k <= SEGS; k++) begin
            sig_knot[k]  = knot_level(-32768 + (k * 65536) / SEGS, 1'b0);
            tanh_knot[k] = knot_level(-32768 + (k * 65536) / SEGS, 1'b1);
        end
    end

    // Track registers, predict accepted requests, check results, watchdog
    always @(posedge i_clk) begin
        t_hidden_result want;
        bit             moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TRAINING:  cfg_training = i_cfg_data[0];
                    CFG_ZO_ENABLE: cfg_zo_en    = i_cfg_data[0];
                    CFG_ZO_PROB:   cfg_zo_prob  = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                pending_hidden.push_back(req_typed ? req_want : predict_update(req_cur));
                n_accepted++;
                moved = 1'b1;
            end
            if (o_strobe) begin
                moved = 1'b1;
                if (pending_hidden.size() == 0) begin
                    $error("result with no request pending");
                    n_mismatch++;
                end else begin
                    want = pending_hidden.pop_front();
                    if (o_new_hidden !== want.new_hidden) begin
                        $error("new_hidden: expected %0d, got %0d",
                               want.new_hidden, o_new_hidden);
                        n_mismatch++;
                    end
                    if (o_update_gate !== want.update_gate) begin
                        $error("update_gate: expected %0d, got %0d",
                               want.update_gate, o_update_gate);
                        n_mismatch++;
                    end
                    if (o_candidate !== want.candidate) begin
                        $error("candidate: expected %0d, got %0d",
                               want.candidate, o_candidate);
                        n_mismatch++;
                    end
                    if (o_activations_valid !== want.act_valid) begin
                        $error("activations_valid: expected %0d, got %0d",
                               want.act_valid, o_activations_valid);
                        n_mismatch++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** gated_recurrent_cell_update_top: FAILED **");
                $finish;
            end
        end
    end

    // Hold the sender until every pending result has come back
    task automatic wait_drained();
        start = 1'b0;
        while (pending_hidden.size() != 0) @(negedge i_clk);
    endtask

    // Write all three registers while the block is idle
    task automatic apply_cfg(bit tr, bit en, logic [12:0] prob, bit noisy);
        logic [11:0] junk;
        wait_drained();
        junk        = noisy ? 12'($urandom()) : 12'd0;
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_TRAINING;
        i_cfg_data  = {junk, tr};
        @(negedge i_clk);
        junk        = noisy ? 12'($urandom()) : 12'd0;
        i_cfg_index = CFG_ZO_ENABLE;
        i_cfg_data  = {junk, en};
        @(negedge i_clk);
        i_cfg_index = CFG_ZO_PROB;
        i_cfg_data  = prob;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Present one request after an optional gap and hold it until taken
    task automatic send_request(t_cell_req r, int gap, bit typed, t_hidden_result want);
        int target;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_cur   = r;
        req_typed = typed;
        req_want  = want;
        start     = 1'b1;
        target    = n_accepted + 1;
        do @(negedge i_clk); while (n_accepted < target);
    endtask

    task automatic add_dir(bit tr, bit en, logic [12:0] prob, int u, int c, int h,
                           bit keep, bit typed, int wh, int wg, int wc, bit wv);
        t_dir_row row;
        row.training = tr;
        row.zo_en    = en;
        row.zo_prob  = prob;
        for (int i = 0; i < 4; i++) begin
            row.req.upd[i]  = 16'(u);
            row.req.cand[i] = 16'(c);
        end
        row.req.prev              = 16'(h);
        row.req.keep              = keep;
        row.typed                 = typed;
        row.want.new_hidden       = 16'(wh);
        row.want.update_gate      = 13'(wg);
        row.want.candidate        = 14'(wc);
        row.want.act_valid        = wv;
        dir_rows.push_back(row);
    endtask

    function automatic int pick_mode();
        int r;
        r = $urandom_range(0, 99);
        return (r < 25) ? 0 : ((r < 85) ? 1 : 2);
    endfunction

    // Full-range, small-magnitude or extreme term
    function automatic logic [15:0] rand_term(int mode);
        case (mode)
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 8191) - 4096);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
        endcase
    endfunction

    function automatic t_cell_req random_req();
        t_cell_req r;
        int        mu;
        int        mc;
        mu = pick_mode();
        mc = pick_mode();
        for (int i = 0; i < 4; i++) begin
            r.upd[i]  = rand_term(mu);
            r.cand[i] = rand_term(mc);
        end
        r.prev = ($urandom_range(0, 1) != 0) ? 16'($urandom()) : rand_term(pick_mode());
        r.keep = $urandom_range(0, 1);
        return r;
    endfunction

    function automatic int pick_gap(bit gaps_on);
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stimulus
    initial begin
        t_hidden_result none;
        t_dir_row       row;
        bit             tr;
        bit             en;
        logic [12:0]    prob;
        bit             cfg_known;
        bit             cur_tr;
        bit             cur_en;
        logic [12:0]    cur_prob;

        none         = '{default: '0};
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_TRAINING;
        i_cfg_data   = '0;
        req_cur      = '{upd: '0, cand: '0, prev: '0, keep: 1'b0};
        req_typed    = 1'b0;
        req_want     = none;
        cfg_training = 1'b0;
        cfg_zo_en    = 1'b0;
        cfg_zo_prob  = '0;
        n_accepted   = 0;
        n_mismatch   = 0;
        idle_cycles  = 0;
        cfg_known    = 1'b0;
        cur_tr       = 1'b0;
        cur_en       = 1'b0;
        cur_prob     = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: training, enable, prob, update term, cand term,
        // prev hidden, keep, typed flag, then hidden, gate, cand, valid
        // Zero inputs out of reset: gate and candidate cleared in inference
        add_dir(0, 0, 0,         0,      0,      0, 1, 1,      0, 0, 0, 0);
        // Sums saturate high and low
        add_dir(0, 0, 0,     32767,  32767,  32767, 1, 0, 0, 0, 0, 0);
        add_dir(0, 0, 0,    -32768, -32768, -32768, 0, 0, 0, 0, 0, 0);
        add_dir(0, 0, 0,      1024,  -1024, -20000, 1, 0, 0, 0, 0, 0);
        // Full-weight inference blend returns the old hidden value
        add_dir(0, 1, 4096,   3000,   -500,  12345, 1, 1,  12345, 0, 0, 0);
        add_dir(0, 1, 4096, -32768,  32767, -32768, 0, 1, -32768, 0, 0, 0);
        // Probability above one saturates to one
        add_dir(0, 1, 8191,    700,    700,  32767, 1, 1,  32767, 0, 0, 0);
        add_dir(0, 1, 4097,   -700,   2000,  -1234, 0, 1,  -1234, 0, 0, 0);
        add_dir(0, 1, 1,       512,   4000, -30000, 1, 0, 0, 0, 0, 0);
        add_dir(0, 1, 2048,   -512,  -4000,  30000, 1, 0, 0, 0, 0, 0);
        add_dir(0, 1, 4095,    100,   -100, -32768, 1, 0, 0, 0, 0, 0);
        // Zoneout disabled with a probability set
        add_dir(0, 0, 4096,    100,    300,  20000, 0, 0, 0, 0, 0, 0);
        // Zero probability leaves zoneout off even in training
        add_dir(1, 1, 0,       200,   -300, -25000, 0, 0, 0, 0, 0, 0);
        // Training at zero input: sigmoid half, tanh zero
        add_dir(1, 0, 0,         0,      0,      0, 1, 1,      0, 2048, 0, 1);
        add_dir(1, 0, 0,     32767,  32767, -32768, 1, 0, 0, 0, 0, 0);
        add_dir(1, 0, 0,    -32768, -32768,  32767, 0, 0, 0, 0, 0, 0);
        // Sum lands exactly on a knot
        add_dir(1, 0, 0,       512,   -512,   4096, 1, 0, 0, 0, 0, 0);
        // Training mask keeps or replaces
        add_dir(1, 1, 100,    1500,   2500,  32767, 0, 0, 0, 0, 0, 0);
        add_dir(1, 1, 100,    1500,   2500,  32767, 1, 0, 0, 0, 0, 0);
        add_dir(1, 1, 8191,  -2047,  -2049, -32768, 0, 0, 0, 0, 0, 0);
        add_dir(1, 1, 8191,   8191,  -8193,     -1, 1, 0, 0, 0, 0, 0);
        add_dir(1, 0, 0,        -1,      1,      1, 1, 0, 0, 0, 0, 0);

        // Walk the table, rewriting registers whenever the setting changes
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (!cfg_known || row.training != cur_tr || row.zo_en != cur_en
                    || row.zo_prob != cur_prob) begin
                apply_cfg(row.training, row.zo_en, row.zo_prob, 1'b0);
                cfg_known = 1'b1;
                cur_tr    = row.training;
                cur_en    = row.zo_en;
                cur_prob  = row.zo_prob;
            end
            send_request(row.req, $urandom_range(0, 2), row.typed, row.want);
        end

        // Random phases over several settings, extremes included
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin tr = 0; en = 0; prob = 13'd0; end
                1: begin tr = 1; en = 0; prob = 13'($urandom()); end
                2: begin tr = 1; en = 1; prob = 13'd4096; end
                3: begin tr = 0; en = 1; prob = 13'd4096; end
                4: begin tr = 0; en = 1; prob = 13'($urandom_range(1, 4095)); end
                5: begin tr = 1; en = 1; prob = 13'($urandom_range(1, 8191)); end
                6: begin tr = 0; en = 1; prob = 13'($urandom_range(4097, 8191)); end
                default: begin tr = 0; en = 1; prob = 13'd1; end
            endcase
            apply_cfg(tr, en, prob, 1'b1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Now and then let the pipeline empty completely
                if ($urandom_range(0, 149) == 0) wait_drained();
                send_request(random_req(), pick_gap(ph % 3 != 0), 1'b0, none);
            end
        end

        // Drain, then allow stray strobes to show up
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (n_mismatch == 0) begin
            $display("** gated_recurrent_cell_update_top: PASSED **");
        end else begin
            $display("** gated_recurrent_cell_update_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/grcu_pkg.sv
sv/grcu_pwl.sv
sv/gated_recurrent_cell_update_top.sv
test/tb_gated_recurrent_cell_update_top.sv
